// ===== hw/rtl/ach_pkg.sv =====
// shared types, constants and codes for the alpha coverage histogram
// used by ach_divider and alpha_coverage_histogram; no dependencies
`timescale 1ns / 1ps

package ach_pkg;

   localparam int COUNT_BITS   = 32;
   localparam int NUM_BINS     = 256;
   localparam int BIN_BITS     = $clog2(NUM_BINS);
   localparam int LEVEL_BITS   = BIN_BITS + 1;
   localparam int ACC_BITS     = COUNT_BITS + BIN_BITS;
   localparam int FRAC_BITS    = 17;
   localparam int FRAC_SHIFT   = FRAC_BITS - 1;
   localparam int DIV_NUM_BITS = COUNT_BITS + FRAC_SHIFT;
   localparam int DIV_CNT_BITS = $clog2(FRAC_BITS + 1);
   localparam int PCT_BITS     = 7;
   localparam int PROD_BITS    = COUNT_BITS + PCT_BITS;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [FRAC_BITS-1:0]  FRAC_ONE  = FRAC_BITS'(1) << FRAC_SHIFT;

   // band limits in percent
   localparam int PCT_FULL    = 100;
   localparam int CARD_LO_PCT = 2;
   localparam int CARD_HI_PCT = 90;
   localparam int MESH_LO_PCT = 30;
   localparam int MESH_HI_PCT = 100;

   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_QUERY = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [1:0] ROLE_CARD = 2'd0;

   localparam logic [1:0] VERDICT_OK     = 2'd0;
   localparam logic [1:0] VERDICT_SPARSE = 2'd1;
   localparam logic [1:0] VERDICT_SOLID  = 2'd2;

   typedef struct packed {
      logic [1:0]            op;
      logic [7:0]            alpha;
      logic [LEVEL_BITS-1:0] cutoff_level;
      logic [1:0]            role;
   } ach_req_type;

   typedef struct packed {
      logic [FRAC_BITS-1:0] pass_fraction;
      logic [1:0]           verdict;
   } ach_rsp_type;

   typedef struct packed {
      logic                    start;
      logic [DIV_NUM_BITS-1:0] dividend;
      logic [COUNT_BITS-1:0]   divisor;
   } ach_div_req_type;

   typedef struct packed {
      logic                 done;
      logic [FRAC_BITS-1:0] quotient;
   } ach_div_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_TAIL,
      ST_PREP,
      ST_DIVIDE,
      ST_OUT
   } ach_state_type;

endpackage

// ===== hw/rtl/ach_divider.sv =====
// restoring divider, one quotient bit per cycle, FRAC_BITS steps
// depends on ach_pkg
`timescale 1ns / 1ps

module ach_divider
   import ach_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  ach_div_req_type div_req,
   output ach_div_rsp_type div_rsp
);

   logic [COUNT_BITS-1:0]   rem_ff, rem_in;
   logic [FRAC_BITS-1:0]    quot_ff, quot_in;
   logic [COUNT_BITS-1:0]   divisor_ff, divisor_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;

   logic [COUNT_BITS:0]     trial;
   logic                    fits;

   assign trial = {rem_ff, quot_ff[FRAC_BITS-1]};
   assign fits  = trial >= {1'b0, divisor_ff};

   always_comb begin
      rem_in     = rem_ff;
      quot_in    = quot_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (div_req.start) begin
         // high part of the dividend is already below the divisor
         rem_in     = COUNT_BITS'(div_req.dividend[DIV_NUM_BITS-1:FRAC_BITS]);
         quot_in    = div_req.dividend[FRAC_BITS-1:0];
         divisor_in = div_req.divisor;
         cnt_in     = '0;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = COUNT_BITS'(trial - {1'b0, divisor_ff});
         end else begin
            rem_in = trial[COUNT_BITS-1:0];
         end
         quot_in = {quot_ff[FRAC_BITS-2:0], fits};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_BITS'(FRAC_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;

endmodule

// ===== hw/rtl/alpha_coverage_histogram.sv =====
// alpha coverage histogram: one add is taken every cycle while idle
// (bin memory read, increment and write back, forwarded across back-to-back adds)
// query: bin sweep, tail and prep states, 17 divide steps, then the result is held
// in the out state until taken; no item is taken until it is delivered
// a query or clear right behind an add waits for the write back; reset and clear
// drop the per-bin valid bits at once; needs ach_divider
`timescale 1ns / 1ps

module alpha_coverage_histogram
   import ach_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  ach_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output ach_rsp_type rsp_data
);

   ach_state_type state_ff, state_in;

   logic [COUNT_BITS-1:0] count_mem [NUM_BINS];
   logic [COUNT_BITS-1:0] rd_data_ff;
   logic [BIN_BITS-1:0]   rd_addr;
   logic [NUM_BINS-1:0]   bin_valid_ff, bin_valid_in;

   logic                  s1_valid_ff, s1_valid_in;
   logic [BIN_BITS-1:0]   s1_bin_ff, s1_bin_in;
   logic [COUNT_BITS-1:0] s1_base, s1_next;
   logic                  fwd_valid_ff;
   logic [BIN_BITS-1:0]   fwd_bin_ff;
   logic [COUNT_BITS-1:0] fwd_count_ff;

   logic [COUNT_BITS-1:0] total_ff, total_in;

   logic [BIN_BITS-1:0]   sweep_addr_ff, sweep_addr_in;
   logic                  sweep_pend_ff, sweep_pend_in;
   logic [BIN_BITS-1:0]   sweep_bin_ff;
   logic [ACC_BITS-1:0]   passed_ff, passed_in;
   logic [LEVEL_BITS-1:0] level_ff, level_in;
   logic                  card_ff, card_in;

   logic                  empty_ff, above_ff;
   logic                  over_ff;
   logic [PROD_BITS-1:0]  p100_ff, lo_ff, hi_ff;
   logic [COUNT_BITS-1:0] passed_low;

   logic [FRAC_BITS-1:0]  frac_ff, frac_in;
   logic [1:0]            verdict_ff, verdict_in;

   logic                  take;
   logic                  add_take, query_take, clear_take;
   logic                  sweep_issue, div_start, out_load;

   ach_div_req_type       div_req;
   ach_div_rsp_type       div_rsp;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (query_take) state_in = ST_SWEEP;
         ST_SWEEP:  if (sweep_addr_ff == BIN_BITS'(NUM_BINS - 1)) state_in = ST_TAIL;
         ST_TAIL:   state_in = ST_PREP;
         ST_PREP:   state_in = ST_DIVIDE;
         ST_DIVIDE: if (div_rsp.done) state_in = ST_OUT;
         ST_OUT:    if (!rsp_stall) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_stall   = 1'b1;
      sweep_issue = 1'b0;
      div_start   = 1'b0;
      out_load    = 1'b0;
      rsp_valid   = 1'b0;
      unique case (state_ff)
         // query and clear wait for the pending write back
         ST_IDLE:   req_stall = s1_valid_ff && (req_data.op != OP_ADD);
         ST_SWEEP:  sweep_issue = 1'b1;
         ST_TAIL:   ;
         ST_PREP:   div_start = 1'b1;
         ST_DIVIDE: out_load = div_rsp.done;
         ST_OUT:    rsp_valid = 1'b1;
         default:   ;
      endcase
   end

   assign take       = req_valid && !req_stall;
   assign add_take   = take && (req_data.op == OP_ADD);
   assign query_take = take && (req_data.op == OP_QUERY);
   assign clear_take = take && (req_data.op == OP_CLEAR);

   // bin memory
   assign rd_addr = sweep_issue ? sweep_addr_ff : req_data.alpha;

   always_ff @(posedge clock) begin
      rd_data_ff <= count_mem[rd_addr];
      if (s1_valid_ff) begin
         count_mem[s1_bin_ff] <= s1_next;
      end
   end

   always_comb begin
      priority if (fwd_valid_ff && (fwd_bin_ff == s1_bin_ff)) begin
         s1_base = fwd_count_ff;
      end else if (bin_valid_ff[s1_bin_ff]) begin
         s1_base = rd_data_ff;
      end else begin
         s1_base = '0;
      end
      s1_next = (s1_base == COUNT_MAX) ? s1_base : s1_base + 1'b1;
   end

   always_comb begin
      s1_valid_in  = add_take;
      s1_bin_in    = req_data.alpha;
      bin_valid_in = bin_valid_ff;
      total_in     = total_ff;
      if (s1_valid_ff) begin
         bin_valid_in[s1_bin_ff] = 1'b1;
      end
      if (add_take && (total_ff != COUNT_MAX)) begin
         total_in = total_ff + 1'b1;
      end
      if (clear_take) begin
         bin_valid_in = '0;
         total_in     = '0;
      end
   end

   // sweep and accumulate
   always_comb begin
      sweep_addr_in = sweep_issue ? sweep_addr_ff + 1'b1 : '0;
      sweep_pend_in = sweep_issue;
      passed_in     = passed_ff;
      level_in      = level_ff;
      card_in       = card_ff;
      if (query_take) begin
         passed_in = '0;
         level_in  = req_data.cutoff_level;
         card_in   = req_data.role == ROLE_CARD;
      end else if (sweep_pend_ff && bin_valid_ff[sweep_bin_ff]
                   && ({1'b0, sweep_bin_ff} >= level_ff)) begin
         passed_in = passed_ff + ACC_BITS'(rd_data_ff);
      end
   end

   assign passed_low = passed_ff[COUNT_BITS-1:0];

   // rounded dividend; only used when passed is below the total
   assign div_req.start    = div_start;
   assign div_req.dividend = {passed_low, {FRAC_SHIFT{1'b0}}}
                             + DIV_NUM_BITS'(total_ff >> 1);
   assign div_req.divisor  = total_ff;

   ach_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // result
   always_comb begin
      frac_in    = frac_ff;
      verdict_in = verdict_ff;
      if (out_load) begin
         priority if (empty_ff) begin
            frac_in = '0;
         end else if (over_ff || (div_rsp.quotient > FRAC_ONE)) begin
            frac_in = FRAC_ONE;
         end else begin
            frac_in = div_rsp.quotient;
         end
         priority if (empty_ff) begin
            verdict_in = VERDICT_SPARSE;
         end else if (above_ff) begin
            verdict_in = VERDICT_SOLID;
         end else if (p100_ff < lo_ff) begin
            verdict_in = VERDICT_SPARSE;
         end else if (p100_ff > hi_ff) begin
            verdict_in = VERDICT_SOLID;
         end else begin
            verdict_in = VERDICT_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         s1_valid_ff   <= 1'b0;
         fwd_valid_ff  <= 1'b0;
         bin_valid_ff  <= '0;
         total_ff      <= '0;
         sweep_addr_ff <= '0;
         sweep_pend_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         s1_valid_ff   <= s1_valid_in;
         fwd_valid_ff  <= s1_valid_ff;
         bin_valid_ff  <= bin_valid_in;
         total_ff      <= total_in;
         sweep_addr_ff <= sweep_addr_in;
         sweep_pend_ff <= sweep_pend_in;
      end
      s1_bin_ff    <= s1_bin_in;
      fwd_bin_ff   <= s1_bin_ff;
      fwd_count_ff <= s1_next;
      sweep_bin_ff <= sweep_addr_ff;
      passed_ff    <= passed_in;
      level_ff     <= level_in;
      card_ff      <= card_in;
      frac_ff      <= frac_in;
      verdict_ff   <= verdict_in;
      if (div_start) begin
         empty_ff <= total_ff == '0;
         over_ff  <= passed_ff >= ACC_BITS'(total_ff);
         above_ff <= passed_ff > ACC_BITS'(total_ff);
         p100_ff  <= PROD_BITS'(passed_low) * PROD_BITS'(PCT_FULL);
         lo_ff    <= PROD_BITS'(total_ff)
                     * PROD_BITS'(card_ff ? CARD_LO_PCT : MESH_LO_PCT);
         hi_ff    <= PROD_BITS'(total_ff)
                     * PROD_BITS'(card_ff ? CARD_HI_PCT : MESH_HI_PCT);
      end
   end

   assign rsp_data.pass_fraction = frac_ff;
   assign rsp_data.verdict       = verdict_ff;

endmodule
